@@ hw/rtl/nddi_pkg.sv @@
// ----------------------------------------------------------------------------
// Newton interpolator package
// Shared types and fixed constants of the divided-difference interpolator.
// ----------------------------------------------------------------------------
package nddi_pkg;

    localparam int COEF_FRAC = 24;   // fraction bits of a stored coefficient
    localparam int COEF_W    = 48;   // coefficient width

    typedef enum logic [2:0] {
        ST_NODE_OK     = 3'd0,
        ST_TABLE_READY = 3'd1,
        ST_EVAL        = 3'd2,
        ST_NOT_READY   = 3'd3,
        ST_DUP         = 3'd4,
        ST_SAT         = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DUP_RI,
        S_DUP_RJ,
        S_DUP_CMP,
        S_BLD_R0,
        S_BLD_R1,
        S_BLD_R2,
        S_BLD_DIV,
        S_EV_R0,
        S_EV_R1,
        S_EV_RA,
        S_EV_RB,
        S_EV_M1,
        S_EV_M2,
        S_EV_M3,
        S_EV_PROD,
        S_EV_SUM,
        S_EV_FIN,
        S_EMIT
    } t_state;

endpackage

@@ hw/rtl/nddi_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nddi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/nddi_divu.sv @@
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring division, one quotient bit per cycle; quotient truncated toward
// zero with FRAC_BITS extra fraction bits and clamped to 48 bits signed.
// ----------------------------------------------------------------------------
module nddi_divu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [48:0]  i_num,
    input  logic signed [32:0]  i_den,
    output logic                o_done,
    output logic signed [47:0]  o_quot
);
    import nddi_pkg::*;

    localparam int DW = 49 + FRAC_BITS;
    localparam int NW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_quo;
    logic [32:0]   r_rem;
    logic [32:0]   r_d;
    logic          r_neg;
    logic [47:0]   r_quot;

    logic [48:0]   w_a;
    logic [32:0]   w_dmag;
    logic [33:0]   w_rs;
    logic          w_ge;
    logic [33:0]   w_diff;
    logic          w_big;
    logic [47:0]   w_qm;

    always_comb begin
        w_a    = i_num[48] ? 49'(-i_num) : 49'(i_num);
        w_dmag = i_den[32] ? 33'(-i_den) : 33'(i_den);
        w_rs   = {r_rem, r_dvd[DW-1]};
        w_ge   = (w_rs >= {1'b0, r_d});
        w_diff = w_rs - {1'b0, r_d};
        w_qm   = r_quo[47:0];
        w_big  = (|r_quo[DW-1:48]) | w_qm[47];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DW);
                r_dvd  <= {w_a, {FRAC_BITS{1'b0}}};
                r_quo  <= '0;
                r_rem  <= '0;
                r_d    <= w_dmag;
                r_neg  <= i_num[48] ^ i_den[32];
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[32:0] : w_rs[32:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_dvd <= {r_dvd[DW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                // clamp the magnitude to the signed 48-bit range
                if (r_neg) begin
                    r_quot <= w_big ? {1'b1, 47'd0} : 48'(-w_qm);
                end else begin
                    r_quot <= w_big ? {1'b0, {47{1'b1}}} : w_qm;
                end
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hw/rtl/newton_divided_difference_interp.sv @@
// ----------------------------------------------------------------------------
// Newton divided-difference interpolator
// Loads interpolation nodes, builds Newton coefficients in place and
// evaluates the Newton form at a fractional query point.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: tuser is the item kind (0 load a node, 1 evaluate); tdata
//   carries node_x, node_y, query_x and query_degree. Every item gives one
//   result item: tuser the status code, tdata the Q16.16 value.
//   The node count is node_degree+1, with 0 taken as 1, at most MAX_NODES.
//   The user must write node_degree on the config port only while idle;
//   the block itself does not enforce this.
// Operation
//   The load that completes the table runs a duplicate scan over every node
//   pair and then one division per divided difference on the bit-serial
//   divider. An evaluate of degree m runs m Horner steps, each using the
//   24x33 multiplication twice. No new item is taken while an item is at
//   work.
// Reset and stall
//   Reset empties the table, clears the flags and sets node_degree to 3;
//   the node and coefficient memories are not cleared. A result waits in the
//   output register while the receiver stalls; the block takes the next
//   item meanwhile but holds its own result until the register is free.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp #(
    parameter int MAX_NODES = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration: node_degree
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    // input items
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [103:0]  i_s_axis_tdata,  // node_x, node_y, query_x, query_degree, pad
    input  logic          i_s_axis_tuser,  // kind
    // result items
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [31:0]   o_m_axis_tdata,  // value
    output logic [2:0]    o_m_axis_tuser   // status
);
    import nddi_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = AW + 1;
    localparam int SH = COEF_FRAC - FRAC_BITS;
    localparam logic signed [47:0] C_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] C_MIN = {1'b1, 47'd0};

    // item fields
    logic signed [31:0] w_node_x, w_node_y, w_query_x;
    logic [3:0]         w_query_degree;
    logic               w_kind;

    assign w_node_x       = i_s_axis_tdata[31:0];
    assign w_node_y       = i_s_axis_tdata[63:32];
    assign w_query_x      = i_s_axis_tdata[95:64];
    assign w_query_degree = i_s_axis_tdata[99:96];
    assign w_kind         = i_s_axis_tuser;

    t_state r_state, n_state;

    logic [3:0]    r_node_degree;
    logic [CW-1:0] r_count;
    logic          r_tbl_ready;
    logic          r_tbl_err;
    logic [CW-1:0] r_n;
    logic [AW-1:0] r_i, r_j, r_m;
    logic signed [31:0] r_q;
    logic signed [31:0] r_xa;
    logic signed [47:0] r_ca, r_cb, r_s, r_p;
    logic [47:0]   r_a;
    logic [32:0]   r_b;
    logic          r_neg, r_sat;
    logic [56:0]   r_pp;
    logic [80:0]   r_acc;
    t_status       r_rs;
    logic signed [31:0] r_rv;
    logic          r_ovalid;
    t_status       r_ostat;
    logic [31:0]   r_oval;

    // memory ports
    logic          w_x_we, w_c_we;
    logic [AW-1:0] w_x_waddr, w_c_waddr, w_x_raddr, w_c_raddr;
    logic [31:0]   w_x_wdata, w_x_rdata;
    logic [47:0]   w_c_wdata, w_c_rdata;
    logic          w_div_start, w_div_done;
    logic signed [47:0] w_div_quot;
    logic signed [48:0] w_div_num;
    logic signed [32:0] w_div_den;

    // control decode
    logic          w_accept, w_restart, w_oload;
    logic [CW-1:0] w_eff, w_target, w_widx;
    logic [3:0]    w_nd1;
    logic [7:0]    w_m8;

    always_comb begin
        w_nd1 = (r_node_degree == 4'd0) ? 4'd1 : r_node_degree;
        if (32'(w_nd1) > MAX_NODES - 1) begin
            w_eff = CW'(MAX_NODES - 1);
        end else begin
            w_eff = CW'(w_nd1);
        end
        w_target  = w_eff + 1'b1;
        w_accept  = i_s_axis_tvalid & o_s_axis_tready;
        w_restart = r_tbl_ready | r_tbl_err | (r_count >= w_target);
        w_widx    = w_restart ? '0 : r_count;
        // clamp the evaluation degree to the table and the configured degree
        w_m8 = {4'd0, w_query_degree};
        if (w_m8 > 8'(r_count) - 8'd1) begin
            w_m8 = 8'(r_count) - 8'd1;
        end
        if (w_m8 > 8'(w_eff)) begin
            w_m8 = 8'(w_eff);
        end
        w_oload = (r_state == S_EMIT) & (~r_ovalid | i_m_axis_tready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_kind) begin
                        n_state = (w_widx + 1'b1 == w_target) ? S_DUP_RI : S_EMIT;
                    end else if (r_tbl_err || !r_tbl_ready || r_count == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_EV_R0;
                    end
                end
            end
            S_DUP_RI:  n_state = S_DUP_RJ;
            S_DUP_RJ:  n_state = S_DUP_CMP;
            S_DUP_CMP: begin
                if (r_xa == w_x_rdata) begin
                    n_state = S_EMIT;
                end else if ({1'b0, r_j} + 1'b1 < {1'b0, r_i}) begin
                    n_state = S_DUP_RJ;
                end else if (CW'(r_i) + 1'b1 < r_n) begin
                    n_state = S_DUP_RI;
                end else begin
                    n_state = S_BLD_R0;
                end
            end
            S_BLD_R0:  n_state = S_BLD_R1;
            S_BLD_R1:  n_state = S_BLD_R2;
            S_BLD_R2:  n_state = S_BLD_DIV;
            S_BLD_DIV: begin
                if (w_div_done) begin
                    if (r_i > r_j || CW'(r_j) + 1'b1 < r_n) begin
                        n_state = S_BLD_R0;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EV_R0:   n_state = S_EV_R1;
            S_EV_R1:   n_state = (r_m == '0) ? S_EV_FIN : S_EV_RA;
            S_EV_RA:   n_state = S_EV_RB;
            S_EV_RB:   n_state = S_EV_M1;
            S_EV_M1:   n_state = S_EV_M2;
            S_EV_M2:   n_state = S_EV_M3;
            S_EV_M3:   n_state = S_EV_PROD;
            S_EV_PROD: n_state = S_EV_SUM;
            S_EV_SUM:  n_state = (r_i == AW'(1)) ? S_EV_FIN : S_EV_RA;
            S_EV_FIN:  n_state = S_EMIT;
            S_EMIT:    n_state = w_oload ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory and unit controls
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_x_we    = 1'b0;
        w_c_we    = 1'b0;
        w_x_waddr = w_widx[AW-1:0];
        w_c_waddr = w_widx[AW-1:0];
        w_x_wdata = w_node_x;
        w_c_wdata = 48'({{16{w_node_y[31]}}, w_node_y} <<< SH);
        w_x_raddr = '0;
        w_c_raddr = '0;
        w_div_start = 1'b0;
        w_div_num = {r_ca[47], r_ca} - {w_c_rdata[47], w_c_rdata};
        w_div_den = {r_xa[31], r_xa} - {w_x_rdata[31], w_x_rdata};
        case (r_state)
            S_IDLE: begin
                w_x_we = w_accept & ~w_kind;
                w_c_we = w_accept & ~w_kind;
            end
            S_DUP_RI: w_x_raddr = r_i;
            S_DUP_RJ: w_x_raddr = r_j;
            // re-read the row node so the next column compares against it
            S_DUP_CMP: w_x_raddr = r_i;
            S_BLD_R0: begin
                w_x_raddr = r_i;
                w_c_raddr = r_i;
            end
            S_BLD_R1: begin
                w_x_raddr = r_i - r_j;
                w_c_raddr = r_i - 1'b1;
            end
            S_BLD_R2: w_div_start = 1'b1;
            S_BLD_DIV: begin
                w_c_we    = w_div_done;
                w_c_waddr = r_i;
                w_c_wdata = w_div_quot;
            end
            S_EV_R0: w_c_raddr = r_m;
            S_EV_RA: begin
                w_x_raddr = r_i - 1'b1;
                w_c_raddr = r_i - 1'b1;
            end
            default: begin
                w_x_raddr = '0;
            end
        endcase
    end

    // Horner product and sum helpers
    logic               w_povf, w_pbig;
    logic [47:0]        w_pqm;
    logic signed [32:0] w_t;
    logic signed [48:0] w_sum;
    logic signed [47:0] w_v;

    always_comb begin
        w_pqm  = r_acc[48+FRAC_BITS-1:FRAC_BITS];
        w_povf = |r_acc[80:48+FRAC_BITS];
        w_pbig = w_povf | w_pqm[47];
        w_t    = {r_q[31], r_q} - {w_x_rdata[31], w_x_rdata};
        w_sum  = {r_cb[47], r_cb} + {r_p[47], r_p};
        w_v    = r_s >>> SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_node_degree <= 4'd3;
            r_count       <= '0;
            r_tbl_ready   <= 1'b0;
            r_tbl_err     <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_degree <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rv <= '0;
                        if (!w_kind) begin
                            // store the node; restart the table if it was done, in error or full
                            if (w_restart) begin
                                r_tbl_ready <= 1'b0;
                                r_tbl_err   <= 1'b0;
                            end
                            r_count <= w_widx + 1'b1;
                            r_n     <= w_target;
                            r_i     <= AW'(1);
                            r_j     <= '0;
                            r_rs    <= ST_NODE_OK;
                        end else if (r_tbl_err) begin
                            r_rs <= ST_DUP;
                        end else if (!r_tbl_ready || r_count == '0) begin
                            r_rs <= ST_NOT_READY;
                        end else begin
                            r_q   <= w_query_x;
                            r_m   <= AW'(w_m8);
                            r_i   <= AW'(w_m8);
                            r_sat <= 1'b0;
                        end
                    end
                end
                S_DUP_RJ: r_xa <= w_x_rdata;
                S_DUP_CMP: begin
                    if (r_xa == w_x_rdata) begin
                        r_tbl_err <= 1'b1;
                        r_rs      <= ST_DUP;
                    end else if ({1'b0, r_j} + 1'b1 < {1'b0, r_i}) begin
                        r_j <= r_j + 1'b1;
                    end else if (CW'(r_i) + 1'b1 >= r_n) begin
                        // scan done: start the build at column one
                        r_i <= AW'(r_n - 1'b1);
                        r_j <= AW'(1);
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_j <= '0;
                    end
                end
                S_BLD_R1: begin
                    r_ca <= w_c_rdata;
                    r_xa <= w_x_rdata;
                end
                S_BLD_DIV: begin
                    if (w_div_done) begin
                        if (r_i > r_j) begin
                            r_i <= r_i - 1'b1;
                        end else if (CW'(r_j) + 1'b1 < r_n) begin
                            r_j <= r_j + 1'b1;
                            r_i <= AW'(r_n - 1'b1);
                        end else begin
                            r_tbl_ready <= 1'b1;
                            r_rs        <= ST_TABLE_READY;
                        end
                    end
                end
                S_EV_R1: r_s <= w_c_rdata;
                S_EV_RB: begin
                    r_cb  <= w_c_rdata;
                    r_a   <= r_s[47] ? 48'(-r_s) : 48'(r_s);
                    r_b   <= w_t[32] ? 33'(-w_t) : 33'(w_t);
                    r_neg <= r_s[47] ^ w_t[32];
                end
                S_EV_M1: r_pp <= r_a[23:0] * r_b;
                S_EV_M2: begin
                    r_acc <= {24'd0, r_pp};
                    r_pp  <= r_a[47:24] * r_b;
                end
                S_EV_M3: r_acc <= r_acc + {r_pp, 24'd0};
                S_EV_PROD: begin
                    // truncate toward zero and clamp the product
                    if (r_neg) begin
                        r_p <= w_pbig ? C_MIN : 48'(-w_pqm);
                        if (w_povf || (w_pqm[47] && |w_pqm[46:0])) begin
                            r_sat <= 1'b1;
                        end
                    end else begin
                        r_p <= w_pbig ? C_MAX : w_pqm;
                        if (w_pbig) begin
                            r_sat <= 1'b1;
                        end
                    end
                end
                S_EV_SUM: begin
                    if (w_sum[48] != w_sum[47]) begin
                        r_s   <= w_sum[48] ? C_MIN : C_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_s <= w_sum[47:0];
                    end
                    r_i <= r_i - 1'b1;
                end
                S_EV_FIN: begin
                    // floor to the output format and clamp to 32 bits
                    if (w_v[47:31] != {17{w_v[47]}}) begin
                        r_rv <= w_v[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                        r_rs <= ST_SAT;
                    end else begin
                        r_rv <= w_v[31:0];
                        r_rs <= r_sat ? ST_SAT : ST_EVAL;
                    end
                end
                default: begin
                    r_rs <= r_rs;
                end
            endcase
            // output register
            if (w_oload) begin
                r_ovalid <= 1'b1;
                r_ostat  <= r_rs;
                r_oval   <= r_rv;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_oval;
    assign o_m_axis_tuser  = r_ostat;

    nddi_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_x_we),
        .i_waddr (w_x_waddr),
        .i_wdata (w_x_wdata),
        .i_raddr (w_x_raddr),
        .o_rdata (w_x_rdata)
    );

    nddi_ram #(.WIDTH(COEF_W), .DEPTH(MAX_NODES)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rdata)
    );

    nddi_divu #(.FRAC_BITS(FRAC_BITS)) u_divu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // a table is never both ready and in error
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_tbl_ready && r_tbl_err))
        else $error("table ready and error both set");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES))
        else $error("loaded count beyond store depth");

    // an evaluated result only ever comes from a finished table
    a_eval_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_oload && (r_rs == ST_EVAL || r_rs == ST_SAT) |-> r_tbl_ready)
        else $error("evaluation result without a table");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_BLD_DIV)
        else $error("divider finished outside the build");

endmodule
